// ===== src/i2crbm_pkg.sv =====
// Shared types and constants for the I2C register byte master.
package i2crbm_pkg;

   // Queue sizes between the ports, the front end and the sequencer
   localparam int REQ_DEPTH = 4;
   localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
   localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   // Bits per byte on the bus
   localparam logic [3:0] BYTE_BITS = 4'd8;

   // Bus phases of the sequencer
   typedef enum logic [20:0] {
      PH_IDLE    = 21'h000001,
      PH_ST_A    = 21'h000002,
      PH_ST_B    = 21'h000004,
      PH_ST_C    = 21'h000008,
      PH_WB_LO   = 21'h000010,
      PH_WB_HI   = 21'h000020,
      PH_AK_LO   = 21'h000040,
      PH_AK_HI   = 21'h000080,
      PH_AK_WAIT = 21'h000100,
      PH_AK_END  = 21'h000200,
      PH_RB_HI   = 21'h000400,
      PH_RB_LO   = 21'h000800,
      PH_NK_LO   = 21'h001000,
      PH_NK_HI   = 21'h002000,
      PH_NK_END  = 21'h004000,
      PH_SP_A    = 21'h008000,
      PH_SP_B    = 21'h010000,
      PH_SP_C    = 21'h020000,
      PH_EP_A    = 21'h040000,
      PH_EP_B    = 21'h080000,
      PH_EP_C    = 21'h100000
   } phase_type;

   // Which byte of the transaction is in flight
   typedef enum logic [4:0] {
      STG_DEV  = 5'b00001,
      STG_REG  = 5'b00010,
      STG_DATA = 5'b00100,
      STG_RDEV = 5'b01000,
      STG_READ = 5'b10000
   } stage_type;

   // One tick of input
   typedef struct packed {
      logic       start_request;
      logic       opcode;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   // One tick of output
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_error;
   } rsp_type;

endpackage

// ===== src/i2crbm_front.sv =====
// Front end: packs input ticks and queues them for the sequencer.
module i2crbm_front
   import i2crbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       start_request,
   input  logic       opcode,
   input  logic [7:0] dev_addr,
   input  logic [7:0] reg_addr,
   input  logic [7:0] write_data,
   input  logic       sda_in,
   output logic       item_valid,
   output req_type    item,
   input  logic       item_pop
);

   logic [REQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [REQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [REQ_CNT_W-1:0] count_ff, count_in;
   req_type              slot_ff [REQ_DEPTH];
   req_type              packed_req;
   logic                 push_ok;
   logic                 pop_ok;

   // Pack the input fields into one queue entry
   always_comb begin
      packed_req.start_request = start_request;
      packed_req.opcode        = opcode;
      packed_req.dev_addr      = dev_addr;
      packed_req.reg_addr      = reg_addr;
      packed_req.write_data    = write_data;
      packed_req.sda_in        = sda_in;
   end

   assign full       = (count_ff == REQ_CNT_W'(REQ_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = push & ~full;
   assign pop_ok     = item_pop & item_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= packed_req;
      end
   end

endmodule

// ===== src/i2crbm_seq.sv =====
// Back end: the I2C bus sequencer, one tick per queued item.
module i2crbm_seq
   import i2crbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] phase_ticks,
   input  logic [7:0]  ack_timeout,
   input  logic        item_valid,
   input  req_type     item,
   output logic        item_pop,
   input  logic        rsp_full,
   output logic        rsp_push,
   output rsp_type     rsp
);

   phase_type   phase_ff, phase_in;
   stage_type   stage_ff, stage_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  retry_ff, retry_in;
   logic [15:0] tick_ff, tick_in;
   logic [24:0] saved_ff, saved_in;
   logic [7:0]  read_byte_ff, read_byte_in;

   logic        step;
   logic        start;
   phase_type   cur;
   stage_type   stage_e;
   logic [15:0] tick_e;
   logic [15:0] limit;
   logic        elapsed;
   logic        op;
   logic [7:0]  dev;
   logic        scl;
   logic        sda;
   logic        done;
   logic        err;

   // One tick moves when an item waits and the result queue has room
   assign step     = item_valid & ~rsp_full;
   assign item_pop = step;
   assign rsp_push = step;

   always_comb begin
      phase_in     = phase_ff;
      stage_in     = stage_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      retry_in     = retry_ff;
      tick_in      = tick_ff;
      saved_in     = saved_ff;
      read_byte_in = read_byte_ff;
      done         = 1'b0;
      err          = 1'b0;

      // Latch a request seen while idle; this tick is the first of START
      start = (phase_ff == PH_IDLE) && item.start_request;
      if (start) begin
         saved_in = {item.opcode, item.dev_addr, item.reg_addr, item.write_data};
         stage_e  = STG_DEV;
         cur      = PH_ST_A;
         tick_e   = '0;
      end else begin
         stage_e  = stage_ff;
         cur      = phase_ff;
         tick_e   = tick_ff;
      end
      stage_in = stage_e;
      tick_in  = tick_e;
      phase_in = cur;
      op       = saved_in[24];
      dev      = saved_in[23:16];

      // Line levels driven during this tick
      case (cur)
         PH_ST_B, PH_SP_B, PH_EP_B: begin
            scl = 1'b1;
            sda = 1'b0;
         end
         PH_ST_C, PH_SP_A, PH_EP_A: begin
            scl = 1'b0;
            sda = 1'b0;
         end
         PH_WB_LO: begin
            scl = 1'b0;
            sda = shift_ff[7];
         end
         PH_WB_HI: begin
            scl = 1'b1;
            sda = shift_ff[7];
         end
         PH_AK_LO, PH_AK_END, PH_RB_LO, PH_NK_LO, PH_NK_END: begin
            scl = 1'b0;
            sda = 1'b1;
         end
         default: begin
            scl = 1'b1;
            sda = 1'b1;
         end
      endcase

      // Phase hold: a zero setting counts as one tick
      limit   = (phase_ticks == '0) ? 16'd1 : phase_ticks;
      elapsed = ({1'b0, tick_e} + 17'd1) >= {1'b0, limit};

      if (cur == PH_AK_WAIT) begin
         // Sample SDA once per tick while SCL is high
         if (!item.sda_in) begin
            phase_in = PH_AK_END;
            tick_in  = '0;
         end else if (retry_ff >= ack_timeout) begin
            phase_in = PH_EP_A;
            tick_in  = '0;
         end else begin
            retry_in = retry_ff + 1'b1;
         end
      end else if (cur != PH_IDLE) begin
         if (!elapsed) begin
            tick_in = tick_e + 1'b1;
         end else begin
            tick_in = '0;
            case (cur)
               PH_ST_A: phase_in = PH_ST_B;
               PH_ST_B: phase_in = PH_ST_C;
               PH_ST_C: begin
                  shift_in     = (stage_e == STG_RDEV) ? (dev | 8'h01) : dev;
                  bit_count_in = '0;
                  phase_in     = PH_WB_LO;
               end
               PH_WB_LO: phase_in = PH_WB_HI;
               PH_WB_HI: begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 1'b1;
                  phase_in     = (bit_count_in >= BYTE_BITS) ? PH_AK_LO : PH_WB_LO;
               end
               PH_AK_LO: phase_in = PH_AK_HI;
               PH_AK_HI: begin
                  retry_in = '0;
                  phase_in = PH_AK_WAIT;
               end
               PH_AK_END: begin
                  // Pick the next byte of the transaction
                  case (stage_e)
                     STG_DEV: begin
                        stage_in     = STG_REG;
                        shift_in     = saved_in[15:8];
                        bit_count_in = '0;
                        phase_in     = PH_WB_LO;
                     end
                     STG_REG: begin
                        if (!op) begin
                           stage_in     = STG_DATA;
                           shift_in     = saved_in[7:0];
                           bit_count_in = '0;
                           phase_in     = PH_WB_LO;
                        end else begin
                           stage_in = STG_RDEV;
                           phase_in = PH_ST_A;
                        end
                     end
                     STG_RDEV: begin
                        stage_in     = STG_READ;
                        bit_count_in = '0;
                        shift_in     = '0;
                        phase_in     = PH_RB_HI;
                     end
                     default: phase_in = PH_SP_A;
                  endcase
               end
               PH_RB_HI: begin
                  shift_in = {shift_ff[6:0], item.sda_in};
                  phase_in = PH_RB_LO;
               end
               PH_RB_LO: begin
                  bit_count_in = bit_count_ff + 1'b1;
                  phase_in     = (bit_count_in >= BYTE_BITS) ? PH_NK_LO : PH_RB_HI;
               end
               PH_NK_LO:  phase_in = PH_NK_HI;
               PH_NK_HI:  phase_in = PH_NK_END;
               PH_NK_END: phase_in = PH_SP_A;
               PH_SP_A:   phase_in = PH_SP_B;
               PH_SP_B:   phase_in = PH_SP_C;
               PH_SP_C: begin
                  done = 1'b1;
                  if (op) begin
                     read_byte_in = shift_ff;
                  end
                  phase_in = PH_IDLE;
               end
               PH_EP_A: phase_in = PH_EP_B;
               PH_EP_B: phase_in = PH_EP_C;
               PH_EP_C: begin
                  done     = 1'b1;
                  err      = 1'b1;
                  phase_in = PH_IDLE;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // Result of this tick
   always_comb begin
      rsp.scl_out   = scl;
      rsp.sda_out   = sda;
      rsp.busy_res  = (cur != PH_IDLE);
      rsp.done_res  = done;
      rsp.read_data = read_byte_in;
      rsp.ack_error = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         stage_ff     <= STG_DEV;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         retry_ff     <= '0;
         tick_ff      <= '0;
         saved_ff     <= '0;
         read_byte_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         stage_ff     <= stage_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         retry_ff     <= retry_in;
         tick_ff      <= tick_in;
         saved_ff     <= saved_in;
         read_byte_ff <= read_byte_in;
      end
   end

endmodule

// ===== src/i2crbm_rsp_queue.sv =====
// Result queue between the sequencer and the result ports.
module i2crbm_rsp_queue
   import i2crbm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_push,
   input  rsp_type rsp_in,
   output logic    rsp_full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_out
);

   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   rsp_type              slot_ff [RSP_DEPTH];
   logic                 push_ok;
   logic                 pop_ok;

   assign rsp_full = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_out  = slot_ff[rd_ptr_ff];
   assign push_ok  = rsp_push & ~rsp_full;
   assign pop_ok   = pop & ~empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ===== src/i2c_register_byte_master_core.sv =====
// Single-byte register read/write I2C master, stepped one bus tick per input transfer.
// Each input transfer is one tick of the bit clock and yields exactly one result transfer
// with the SCL/SDA levels for that tick, busy, done, ack error and the last read byte.
// A request on an idle tick starts a register write (opcode 0) or a register read
// (opcode 1); each phase but the ack wait is held for phase_ticks ticks (register at
// 0x0, zero acts as one); an ack wait aborts with STOP and ack_error after more than
// ack_timeout high samples (register at 0x4). Throughput is one transfer per clock
// while the result side keeps up; the sequencer steps one tick per cycle unless the
// result queue is full or no item waits. A result reaches the ports through the
// four-entry request queue and then the two-entry result queue; while the result side
// stalls, the input side keeps accepting until both queues fill, up to six transfers.
module i2c_register_byte_master_core
   import i2crbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input ticks
   input  logic                  push,
   output logic                  full,
   input  logic                  req_start_request,
   input  logic                  req_opcode,
   input  logic [7:0]            req_dev_addr,
   input  logic [7:0]            req_reg_addr,
   input  logic [7:0]            req_write_data,
   input  logic                  req_sda_in,
   // Results
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_scl_out,
   output logic                  rsp_sda_out,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_ack_error,
   // Configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [15:0] phase_ticks_ff;
   logic [7:0]  ack_timeout_ff;
   logic        csr_write;
   logic        item_valid;
   req_type     item;
   logic        item_pop;
   logic        rsp_full;
   logic        rsp_push;
   rsp_type     seq_rsp;
   rsp_type     head_rsp;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         if (paddr[2] == CSR_PHASE_TICKS) begin
            phase_ticks_ff <= pwdata[15:0];
         end else begin
            ack_timeout_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == CSR_PHASE_TICKS) begin
         prdata = {16'd0, phase_ticks_ff};
      end else begin
         prdata = {24'd0, ack_timeout_ff};
      end
   end

   i2crbm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .start_request (req_start_request),
      .opcode        (req_opcode),
      .dev_addr      (req_dev_addr),
      .reg_addr      (req_reg_addr),
      .write_data    (req_write_data),
      .sda_in        (req_sda_in),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   i2crbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .phase_ticks (phase_ticks_ff),
      .ack_timeout (ack_timeout_ff),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp         (seq_rsp)
   );

   i2crbm_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (seq_rsp),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_out  (head_rsp)
   );

   // Result fields
   assign rsp_scl_out   = head_rsp.scl_out;
   assign rsp_sda_out   = head_rsp.sda_out;
   assign rsp_busy_res  = head_rsp.busy_res;
   assign rsp_done_res  = head_rsp.done_res;
   assign rsp_read_data = head_rsp.read_data;
   assign rsp_ack_error = head_rsp.ack_error;

`ifndef SYNTHESIS
   // An accepted tick is waiting for the sequencer on the next cycle
   a_push_queued: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> item_valid)
      else $error("accepted transfer not queued");

   // The sequencer never steps into a full result queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (!rsp_full && item_valid))
      else $error("sequencer stepped without room");

   // An ack error only comes with done on a busy tick
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && seq_rsp.ack_error) |-> (seq_rsp.done_res && seq_rsp.busy_res))
      else $error("ack error without done");
`endif

endmodule

// ===== dv/i2crbm_tb_pkg.sv =====
// Opcodes and register byte addresses shared by the I2C master testbench files.
`timescale 1ns / 1ps

package i2crbm_tb_pkg;
   import i2crbm_pkg::*;

   // Transaction kinds carried in the opcode field
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Byte addresses of the two registers
   localparam logic [CSR_ADDR_W-1:0] ADDR_PHASE_TICKS = {CSR_PHASE_TICKS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_ACK_TIMEOUT = {CSR_ACK_TIMEOUT, 2'b00};

endpackage

// ===== dv/i2crbm_bus_checker.sv =====
// Bus sequencer predictor and result comparison for the I2C register byte master.
`timescale 1ns / 1ps

module i2crbm_bus_checker
   import i2crbm_pkg::*;
   import i2crbm_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic                  req_start_request,
   input  logic                  req_opcode,
   input  logic [7:0]            req_dev_addr,
   input  logic [7:0]            req_reg_addr,
   input  logic [7:0]            req_write_data,
   input  logic                  req_sda_in,
   input  logic                  empty,
   input  logic                  pop,
   input  logic                  rsp_scl_out,
   input  logic                  rsp_sda_out,
   input  logic                  rsp_busy_res,
   input  logic                  rsp_done_res,
   input  logic [7:0]            rsp_read_data,
   input  logic                  rsp_ack_error,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending
);

   // Register copies
   logic [15:0] cfg_hold;
   logic [7:0]  cfg_ack_limit;

   // Sequencer state
   phase_type   bus_phase;
   stage_type   byte_stage;
   logic [3:0]  bit_idx;
   logic [7:0]  shift_q;
   logic [7:0]  ack_misses;
   logic [15:0] hold_cnt;
   logic        held_op;
   logic [7:0]  held_dev;
   logic [7:0]  held_reg;
   logic [7:0]  held_data;
   logic [7:0]  rx_byte;
   logic        scl_drive;
   logic        sda_drive;

   // Results still owed by the block, oldest first
   rsp_type expected_ticks[$];

   task automatic clear_model();
      cfg_hold      = PHASE_TICKS_RESET;
      cfg_ack_limit = ACK_TIMEOUT_RESET;
      bus_phase     = PH_IDLE;
      byte_stage    = STG_DEV;
      bit_idx       = '0;
      shift_q       = '0;
      ack_misses    = '0;
      hold_cnt      = '0;
      held_op       = OP_WRITE;
      held_dev      = '0;
      held_reg      = '0;
      held_data     = '0;
      rx_byte       = '0;
      scl_drive     = 1'b1;
      sda_drive     = 1'b1;
   endtask

   task automatic enter_phase(input phase_type p);
      bus_phase = p;
      hold_cnt  = '0;
   endtask

   task automatic load_tx_byte(input logic [7:0] b);
      shift_q = b;
      bit_idx = '0;
      enter_phase(PH_WB_LO);
   endtask

   // One bus tick: line levels for this tick, then the phase advance
   task automatic advance_bus(input req_type tick, output rsp_type res);
      phase_type   cur;
      logic        fin;
      logic        abort;
      logic        lapsed;
      logic [16:0] hold_limit;
      fin   = 1'b0;
      abort = 1'b0;
      if (bus_phase == PH_IDLE && tick.start_request) begin
         held_op    = tick.opcode;
         held_dev   = tick.dev_addr;
         held_reg   = tick.reg_addr;
         held_data  = tick.write_data;
         byte_stage = STG_DEV;
         enter_phase(PH_ST_A);
      end
      cur = bus_phase;

      case (cur)
         PH_ST_B, PH_SP_B, PH_EP_B: begin
            scl_drive = 1'b1;
            sda_drive = 1'b0;
         end
         PH_ST_C, PH_SP_A, PH_EP_A: begin
            scl_drive = 1'b0;
            sda_drive = 1'b0;
         end
         PH_WB_LO: begin
            scl_drive = 1'b0;
            sda_drive = shift_q[7];
         end
         PH_WB_HI: begin
            scl_drive = 1'b1;
            sda_drive = shift_q[7];
         end
         PH_AK_LO, PH_AK_END, PH_RB_LO, PH_NK_LO, PH_NK_END: begin
            scl_drive = 1'b0;
            sda_drive = 1'b1;
         end
         default: begin
            scl_drive = 1'b1;
            sda_drive = 1'b1;
         end
      endcase

      // Phase hold; a zero setting acts as one tick
      hold_limit = (cfg_hold == '0) ? 17'd1 : {1'b0, cfg_hold};
      lapsed     = 1'b0;
      if (cur != PH_AK_WAIT && cur != PH_IDLE) begin
         if ({1'b0, hold_cnt} + 17'd1 >= hold_limit) lapsed = 1'b1;
         else hold_cnt = hold_cnt + 16'd1;
      end

      if (cur == PH_AK_WAIT) begin
         // one SDA sample per tick, abort once the miss budget is spent
         if (!tick.sda_in) enter_phase(PH_AK_END);
         else if (ack_misses >= cfg_ack_limit) enter_phase(PH_EP_A);
         else ack_misses = ack_misses + 8'd1;
      end else if (lapsed) begin
         case (cur)
            PH_ST_A: enter_phase(PH_ST_B);
            PH_ST_B: enter_phase(PH_ST_C);
            PH_ST_C: begin
               if (byte_stage == STG_RDEV) load_tx_byte({held_dev[7:1], 1'b1});
               else load_tx_byte(held_dev);
            end
            PH_WB_LO: enter_phase(PH_WB_HI);
            PH_WB_HI: begin
               shift_q = {shift_q[6:0], 1'b0};
               bit_idx = bit_idx + 4'd1;
               enter_phase((bit_idx >= BYTE_BITS) ? PH_AK_LO : PH_WB_LO);
            end
            PH_AK_LO: enter_phase(PH_AK_HI);
            PH_AK_HI: begin
               ack_misses = '0;
               enter_phase(PH_AK_WAIT);
            end
            PH_AK_END: begin
               if (byte_stage == STG_DEV) begin
                  byte_stage = STG_REG;
                  load_tx_byte(held_reg);
               end else if (byte_stage == STG_REG && held_op == OP_WRITE) begin
                  byte_stage = STG_DATA;
                  load_tx_byte(held_data);
               end else if (byte_stage == STG_REG) begin
                  // repeated START for the read address
                  byte_stage = STG_RDEV;
                  enter_phase(PH_ST_A);
               end else if (byte_stage == STG_RDEV) begin
                  byte_stage = STG_READ;
                  bit_idx    = '0;
                  shift_q    = '0;
                  enter_phase(PH_RB_HI);
               end else begin
                  enter_phase(PH_SP_A);
               end
            end
            PH_RB_HI: begin
               shift_q = {shift_q[6:0], tick.sda_in};
               enter_phase(PH_RB_LO);
            end
            PH_RB_LO: begin
               bit_idx = bit_idx + 4'd1;
               enter_phase((bit_idx >= BYTE_BITS) ? PH_NK_LO : PH_RB_HI);
            end
            PH_NK_LO:  enter_phase(PH_NK_HI);
            PH_NK_HI:  enter_phase(PH_NK_END);
            PH_NK_END: enter_phase(PH_SP_A);
            PH_SP_A:   enter_phase(PH_SP_B);
            PH_SP_B:   enter_phase(PH_SP_C);
            PH_SP_C: begin
               fin = 1'b1;
               if (held_op == OP_READ) rx_byte = shift_q;
               enter_phase(PH_IDLE);
            end
            PH_EP_A: enter_phase(PH_EP_B);
            PH_EP_B: enter_phase(PH_EP_C);
            PH_EP_C: begin
               fin   = 1'b1;
               abort = 1'b1;
               enter_phase(PH_IDLE);
            end
            default: ;
         endcase
      end

      res.scl_out   = scl_drive;
      res.sda_out   = sda_drive;
      res.busy_res  = (cur != PH_IDLE);
      res.done_res  = fin;
      res.read_data = rx_byte;
      res.ack_error = abort;
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      req_type tick;
      rsp_type want;
      if (reset) begin
         clear_model();
         expected_ticks.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_PHASE_TICKS) cfg_hold = pwdata[15:0];
            else if (paddr == ADDR_ACK_TIMEOUT) cfg_ack_limit = pwdata[7:0];
         end

         // input transfer: predict its result
         if (push && !full) begin
            tick.start_request = req_start_request;
            tick.opcode        = req_opcode;
            tick.dev_addr      = req_dev_addr;
            tick.reg_addr      = req_reg_addr;
            tick.write_data    = req_write_data;
            tick.sda_in        = req_sda_in;
            advance_bus(tick, want);
            expected_ticks.push_back(want);
         end

         // result transfer: compare with the oldest prediction
         if (pop && !empty) begin
            if (expected_ticks.size() == 0) begin
               fail_count++;
               $display("%0t: result transfer with none expected, expected none, got busy=%0b",
                        $time, rsp_busy_res);
            end else begin
               want = expected_ticks.pop_front();
               compare_field("scl_out", 8'(want.scl_out), 8'(rsp_scl_out));
               compare_field("sda_out", 8'(want.sda_out), 8'(rsp_sda_out));
               compare_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
               compare_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
               compare_field("read_data", want.read_data, rsp_read_data);
               compare_field("ack_error", 8'(want.ack_error), 8'(rsp_ack_error));
            end
         end
      end
      pending = expected_ticks.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus, register setup and verdict for the I2C register byte master.
`timescale 1ns / 1ps

module tb_top;
   import i2crbm_pkg::*;
   import i2crbm_tb_pkg::*;

   // Idle levels for both sides
   localparam int GAPS_NONE = 0;
   localparam int GAPS_SOME = 1;
   localparam int GAPS_FULL = 2;

   // SDA patterns for directed transactions
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_TOGGLE = 2;
   localparam int SDA_RAND   = 3;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_start_request;
   logic                  req_opcode;
   logic [7:0]            req_dev_addr;
   logic [7:0]            req_reg_addr;
   logic [7:0]            req_write_data;
   logic                  req_sda_in;
   logic                  empty;
   logic                  pop;
   logic                  rsp_scl_out;
   logic                  rsp_sda_out;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic [7:0]            rsp_read_data;
   logic                  rsp_ack_error;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int gap_level;
   int sent;
   int drained;
   int finished;
   int aborted;
   logic last_busy;

   i2c_register_byte_master_core dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_start_request(req_start_request), .req_opcode(req_opcode),
      .req_dev_addr(req_dev_addr), .req_reg_addr(req_reg_addr),
      .req_write_data(req_write_data), .req_sda_in(req_sda_in),
      .empty(empty), .pop(pop),
      .rsp_scl_out(rsp_scl_out), .rsp_sda_out(rsp_sda_out),
      .rsp_busy_res(rsp_busy_res), .rsp_done_res(rsp_done_res),
      .rsp_read_data(rsp_read_data), .rsp_ack_error(rsp_ack_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   i2crbm_bus_checker u_bus_checker (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_start_request(req_start_request), .req_opcode(req_opcode),
      .req_dev_addr(req_dev_addr), .req_reg_addr(req_reg_addr),
      .req_write_data(req_write_data), .req_sda_in(req_sda_in),
      .empty(empty), .pop(pop),
      .rsp_scl_out(rsp_scl_out), .rsp_sda_out(rsp_sda_out),
      .rsp_busy_res(rsp_busy_res), .rsp_done_res(rsp_done_res),
      .rsp_read_data(rsp_read_data), .rsp_ack_error(rsp_ack_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int pick_gap();
      case (gap_level)
         GAPS_NONE: return 0;
         GAPS_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
         default:   return int'($urandom_range(0, 18));
      endcase
   endfunction

   // Random tick: start one in start_span (never for 0), SDA high sda_eighths/8
   function automatic req_type make_tick(input int start_span, input int sda_eighths);
      req_type t;
      t.start_request = (start_span > 0) && ($urandom_range(1, start_span) == 1);
      t.opcode        = 1'($urandom_range(0, 1));
      t.dev_addr      = 8'($urandom_range(0, 255));
      t.reg_addr      = 8'($urandom_range(0, 255));
      t.write_data    = 8'($urandom_range(0, 255));
      t.sda_in        = ($urandom_range(1, 8) <= sda_eighths);
      return t;
   endfunction

   // Offer one tick; starts and ends on a falling edge
   task automatic send_tick(input req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push              <= 1'b1;
      req_start_request <= t.start_request;
      req_opcode        <= t.opcode;
      req_dev_addr      <= t.dev_addr;
      req_reg_addr      <= t.reg_addr;
      req_write_data    <= t.write_data;
      req_sda_in        <= t.sda_in;
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic run_txn(input logic op, input logic [7:0] dev, input logic [7:0] rg,
                          input logic [7:0] data, input int n, input int sda_mode,
                          input logic keep_start);
      req_type t;
      int k;
      for (k = 0; k < n; k++) begin
         t = make_tick(0, 4);
         t.start_request = (k == 0) || keep_start;
         t.opcode        = op;
         t.dev_addr      = dev;
         t.reg_addr      = rg;
         t.write_data    = data;
         case (sda_mode)
            SDA_LOW:    t.sda_in = 1'b0;
            SDA_HIGH:   t.sda_in = 1'b1;
            SDA_TOGGLE: t.sda_in = k[0];
            default:    ;
         endcase
         send_tick(t);
      end
   endtask

   task automatic run_random(input int n, input int start_span, input int sda_eighths);
      int k;
      for (k = 0; k < n; k++) send_tick(make_tick(start_span, sda_eighths));
   endtask

   // Clock idle ticks with SDA low until a result shows the sequencer idle
   task automatic settle_idle();
      do begin
         run_random(16, 0, 0);
         push <= 1'b0;
         while (pending != 0) @(negedge clock);
      end while (last_busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Result side: random stalls, plus a long hold-off so the input side fills
   initial begin : rsp_drain
      int gap;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap();
         if (drained == 40 || $urandom_range(0, 399) == 0) gap = 150;
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         last_busy = rsp_busy_res;
         if (rsp_done_res) finished++;
         if (rsp_ack_error) aborted++;
         drained++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      push              = 1'b0;
      req_start_request = 1'b0;
      req_opcode        = OP_WRITE;
      req_dev_addr      = '0;
      req_reg_addr      = '0;
      req_write_data    = '0;
      req_sda_in        = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      last_busy         = 1'b0;
      gap_level         = GAPS_FULL;
      reset             = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset settings: idle ticks, a full write, a full read
      run_random(3, 0, 4);
      run_txn(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 70, SDA_LOW, 1'b0);
      run_txn(OP_READ, 8'h00, 8'hFF, 8'h00, 100, SDA_RAND, 1'b0);
      settle_idle();

      // Zero hold and zero ack budget: timeout, requests while busy, random traffic
      csr_write(ADDR_PHASE_TICKS, 32'd0);
      csr_write(ADDR_ACK_TIMEOUT, 32'd0);
      gap_level = GAPS_SOME;
      run_txn(OP_WRITE, 8'h5A, 8'h3C, 8'h00, 30, SDA_HIGH, 1'b0);
      run_txn(OP_READ, 8'hA5, 8'h5A, 8'hC3, 40, SDA_TOGGLE, 1'b1);
      run_random(40, 8, 2);
      settle_idle();

      // Short hold, largest ack budget; upper data bits set to check masking
      csr_write(ADDR_PHASE_TICKS, 32'hFFFF_0002);
      csr_write(ADDR_ACK_TIMEOUT, 32'hFFFF_FFFF);
      gap_level = GAPS_NONE;
      run_random(80, 10, 1);

      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Drove %0d bus ticks: register writes and reads, ack timeouts, busy requests,",
               sent);
      $display("phase hold 0 to 2, ack budget 0 to 255; %0d transactions ended, %0d aborted",
               finished, aborted);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/i2crbm_pkg.sv
src/i2crbm_front.sv
src/i2crbm_seq.sv
src/i2crbm_rsp_queue.sv
src/i2c_register_byte_master_core.sv
dv/i2crbm_tb_pkg.sv
dv/i2crbm_bus_checker.sv
dv/tb_top.sv
